### rtl/mfnm_pkg.sv
// ----------------------------------------------------------------------------
// mfnm_pkg
// Shared constants and types of the masked four-neighbor mean block.
// ----------------------------------------------------------------------------
package mfnm_pkg;

  localparam int MAX_DIM    = 256;
  localparam int VALUE_BITS = 16;
  localparam int CFG_W      = 9;
  localparam int MIN_SIZE   = 3;
  localparam int RESET_SIZE = (64 < MAX_DIM) ? 64 : MAX_DIM;

  localparam int ADDR_W  = $clog2(MAX_DIM);
  localparam int SIZE_W  = $clog2(MAX_DIM + 1);
  localparam int CLAMP_W = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
  localparam int COUNT_W = $clog2(MAX_DIM * MAX_DIM + MAX_DIM + 1);
  localparam int SUM_W   = VALUE_BITS + 2;
  localparam int RESET_TOTAL = RESET_SIZE * RESET_SIZE;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_e;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    value_t row1_value;
    logic   row1_mask;
    value_t row2_value;
  } lb_entry_t;

  typedef struct packed {
    logic      en;
    addr_t     waddr;
    addr_t     raddr;
    lb_entry_t wdata;
  } lb_req_t;

endpackage

### rtl/mfnm_line_buf.sv
// ----------------------------------------------------------------------------
// mfnm_line_buf
// Two-row line buffer: one write and one registered read per advancing beat.
// ----------------------------------------------------------------------------
module mfnm_line_buf (
  input  logic                clk_i,
  input  mfnm_pkg::lb_req_t   req_i,
  output mfnm_pkg::lb_entry_t rdata_o
);

  mfnm_pkg::lb_entry_t mem [mfnm_pkg::MAX_DIM];
  mfnm_pkg::lb_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      mem[req_i.waddr] <= req_i.wdata;
      rdata_q          <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/masked_four_neighbor_mean.sv
// ----------------------------------------------------------------------------
// masked_four_neighbor_mean
// One Jacobi relaxation sweep with a four-point stencil over a square image.
// ----------------------------------------------------------------------------
// Usage:
//   Write matrix_size_i with cfg_we_i to set the side n (held to 3..256);
//   each write restarts the frame. Pixels enter on the in channel in raster
//   order (req_type_i = pixel); after n*n pixels, n drain beats flush the
//   last row. A drain beat inside the frame is taken and dropped.
//   Results leave on the out channel in raster order; the result for pixel k
//   enters the stage register as item k+n is accepted, then the output
//   register once that is free. The first n beats of a frame give no result.
//   Throughput is one beat per cycle while the receiver keeps up, as the line
//   buffer takes one write and one read per cycle. When the receiver stalls,
//   the result holds in the output register and one more item waits in the
//   stage register; in_ready_o then falls until the output drains.
//   Reset sets n to 64 and starts a fresh frame; the line buffer is not
//   cleared, since no result reads an entry before the frame writes it.
// ----------------------------------------------------------------------------
module masked_four_neighbor_mean (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mfnm_pkg::CFG_W-1:0]        matrix_size_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic signed [mfnm_pkg::VALUE_BITS-1:0] sample_i,
  input  logic                              mask_bit_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mfnm_pkg::VALUE_BITS-1:0] out_value_o,
  output logic                              kept_original_o,
  output logic                              last_pixel_o
);

  localparam int AddrW  = mfnm_pkg::ADDR_W;
  localparam int SizeW  = mfnm_pkg::SIZE_W;
  localparam int CountW = mfnm_pkg::COUNT_W;
  localparam int ClampW = mfnm_pkg::CLAMP_W;
  localparam int SumW   = mfnm_pkg::SUM_W;
  localparam int SqW    = 2 * SizeW;

  logic [SizeW-1:0]  size_q, size_new;
  logic [CountW-1:0] total_q, total_new;
  logic [SqW-1:0]    size_sq;
  logic [CountW-1:0] t_q;
  logic [AddrW-1:0]  col_q, row_q, last_idx, col_next;

  logic in_accept, is_drain, in_frame, adv, has_out, border, last;

  logic                s1_valid_q, s1_fire;
  mfnm_pkg::value_t    s1_center_q, s1_above_q, s1_below_q, s1_left_q;
  logic                s1_mask_q, s1_border_q, s1_last_q;

  mfnm_pkg::lb_req_t   lb_req;
  mfnm_pkg::lb_entry_t lb_rdata;

  logic signed [SumW-1:0] sum;
  mfnm_pkg::value_t       mean_value;
  logic                   kept;

  logic             out_valid_q, out_kept_q, out_last_q;
  mfnm_pkg::value_t out_value_q;

  always_comb begin
    if (matrix_size_i < mfnm_pkg::CFG_W'(mfnm_pkg::MIN_SIZE)) begin
      size_new = SizeW'(mfnm_pkg::MIN_SIZE);
    end else if (ClampW'(matrix_size_i) > ClampW'(mfnm_pkg::MAX_DIM)) begin
      size_new = SizeW'(mfnm_pkg::MAX_DIM);
    end else begin
      size_new = SizeW'(matrix_size_i);
    end
  end

  assign size_sq   = SqW'(size_new) * SqW'(size_new);
  assign total_new = CountW'(size_sq);

  assign last_idx = AddrW'(size_q - SizeW'(1));
  assign col_next = (col_q == last_idx) ? '0 : col_q + AddrW'(1);

  assign in_accept = in_valid_i && in_ready_o;
  assign is_drain  = (req_type_i == mfnm_pkg::REQ_DRAIN);
  assign in_frame  = (t_q < total_q);
  assign adv       = in_accept && !(is_drain && in_frame);
  assign has_out   = !(t_q < CountW'(size_q));
  assign border    = (row_q == '0) || (row_q == last_idx) ||
                     (col_q == '0) || (col_q == last_idx);
  assign last      = (row_q == last_idx) && (col_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SizeW'(mfnm_pkg::RESET_SIZE);
      total_q <= CountW'(mfnm_pkg::RESET_TOTAL);
      t_q     <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_we_i) begin
      size_q  <= size_new;
      total_q <= total_new;
      t_q     <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else if (adv) begin
      if (has_out && last) begin
        t_q   <= '0;
        col_q <= '0;
        row_q <= '0;
      end else begin
        t_q   <= t_q + CountW'(1);
        col_q <= col_next;
        if (has_out && (col_q == last_idx)) begin
          row_q <= row_q + AddrW'(1);
        end
      end
    end
  end

  always_comb begin
    lb_req.en               = adv;
    lb_req.waddr            = col_q;
    lb_req.raddr            = col_next;
    lb_req.wdata.row1_value = sample_i;
    lb_req.wdata.row1_mask  = mask_bit_i;
    lb_req.wdata.row2_value = lb_rdata.row1_value;
  end

  mfnm_line_buf u_line_buf (
    .clk_i   (clk_i),
    .req_i   (lb_req),
    .rdata_o (lb_rdata)
  );

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= has_out;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Hold the stencil window; the right neighbor sits in the line buffer read register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_left_q   <= s1_center_q;
      s1_center_q <= lb_rdata.row1_value;
      s1_mask_q   <= lb_rdata.row1_mask;
      s1_above_q  <= lb_rdata.row2_value;
      s1_below_q  <= sample_i;
      s1_border_q <= border;
      s1_last_q   <= last;
    end
  end

  assign sum = SumW'(s1_left_q) + SumW'(lb_rdata.row1_value) +
               SumW'(s1_above_q) + SumW'(s1_below_q);
  assign mean_value = sum[SumW-1:2];
  assign kept       = s1_border_q || s1_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_value_q <= kept ? s1_center_q : mean_value;
      out_kept_q  <= kept;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_value_o     = out_value_q;
  assign kept_original_o = out_kept_q;
  assign last_pixel_o    = out_last_q;

  a_col_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= last_idx)
    else $error("column counter beyond image side");

  a_row_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= last_idx)
    else $error("row counter beyond image side");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_q < total_q + CountW'(size_q))
    else $error("input count past end of frame");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full pipeline");

endmodule

### test/masked_four_neighbor_mean_test.sv
// ----------------------------------------------------------------------------
// masked_four_neighbor_mean_test
// Self-checking bench for the four-neighbor relaxation sweep. Pixel frames of
// many sizes stream through a valid/ready driver while a stencil predictor
// with its own line buffers forecasts every result. The predictor covers size
// clamping, early drains, pixels sent during the flush, cut frames and frame
// restarts. Both channels idle in random bursts, and the receiver holds off
// once for a long stretch so the block fills and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module masked_four_neighbor_mean_test;

  localparam int PIX_DEPTH     = 2 * mfnm_pkg::MAX_DIM + 1;
  localparam int MASK_DEPTH    = mfnm_pkg::MAX_DIM + 1;
  localparam int RANDOM_BEATS  = 100;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 1000;
  localparam logic [mfnm_pkg::CFG_W-1:0] SIZE_ALL_ONES = '1;

  typedef struct packed {
    mfnm_pkg::req_type_e kind;
    mfnm_pkg::value_t    sample;
    logic                mask;
  } beat_t;

  typedef struct packed {
    mfnm_pkg::value_t value;
    logic             kept;
    logic             last;
  } pixel_result_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we      = 1'b0;
  logic [mfnm_pkg::CFG_W-1:0] matrix_size = '0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  mfnm_pkg::req_type_e        req_type    = mfnm_pkg::REQ_DRAIN;
  mfnm_pkg::value_t           sample      = '0;
  logic                       mask_bit    = 1'b0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  mfnm_pkg::value_t           out_value;
  logic                       kept_original;
  logic                       last_pixel;

  beat_t         beat_queue[$];
  pixel_result_t expected_pixels[$];
  beat_t         cur_beat = '0;
  beat_t         next_beat;

  mfnm_pkg::value_t pix_line [PIX_DEPTH];
  logic             mask_line [MASK_DEPTH];
  int unsigned side      = mfnm_pkg::RESET_SIZE;
  int unsigned fed_count = 0;
  int unsigned row_pos   = 0;
  int unsigned col_pos   = 0;

  int mismatch_count   = 0;
  int results_checked  = 0;
  int beats_taken      = 0;
  int frames_closed    = 0;
  int frame_beats      = 0;
  int settings_written = 0;

  bit quiet_tail   = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;
  int tx_gap       = 0;
  int tx_mode_left = 0;
  bit tx_busy      = 1'b1;
  int rx_hold      = 0;
  int rx_mode_left = 0;
  bit rx_busy      = 1'b1;

  masked_four_neighbor_mean dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .matrix_size_i   (matrix_size),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .req_type_i      (req_type),
    .sample_i        (sample),
    .mask_bit_i      (mask_bit),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_value_o     (out_value),
    .kept_original_o (kept_original),
    .last_pixel_o    (last_pixel)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20_000_000);
    $display("FAIL");
    $finish;
  end

  task automatic relax_step(input beat_t b);
    int unsigned   total;
    int unsigned   t;
    int unsigned   k;
    logic signed [mfnm_pkg::SUM_W-1:0] nsum;
    pixel_result_t r;
    total = side * side;
    t = fed_count;
    if (b.kind == mfnm_pkg::REQ_DRAIN && t < total) return;
    if (b.kind == mfnm_pkg::REQ_PIXEL && t < total) begin
      pix_line[t % PIX_DEPTH]   = b.sample;
      mask_line[t % MASK_DEPTH] = b.mask;
    end
    fed_count = t + 1;
    if (t < side) return;
    k = t - side;
    r.kept = row_pos == 0 || row_pos == side - 1 || col_pos == 0 ||
             col_pos == side - 1 || mask_line[k % MASK_DEPTH];
    if (r.kept) begin
      r.value = pix_line[k % PIX_DEPTH];
    end else begin
      nsum = pix_line[(k - 1) % PIX_DEPTH] + pix_line[(k + 1) % PIX_DEPTH] +
             pix_line[(k - side) % PIX_DEPTH] + pix_line[(k + side) % PIX_DEPTH];
      r.value = mfnm_pkg::value_t'(nsum >>> 2);
    end
    r.last = row_pos == side - 1 && col_pos == side - 1;
    if (r.last) begin
      fed_count = 0;
      row_pos   = 0;
      col_pos   = 0;
    end else begin
      col_pos++;
      if (col_pos >= side) begin
        col_pos = 0;
        row_pos++;
      end
    end
    expected_pixels.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             field, results_checked, got, want);
    mismatch_count++;
  endtask

  // drive one beat per free slot, predict on every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        relax_step(cur_beat);
        beats_taken++;
      end
      if (tx_mode_left == 0) begin
        tx_mode_left = $urandom_range(100, 400);
        tx_busy      = ($urandom_range(0, 2) != 0);
      end else begin
        tx_mode_left--;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (beat_queue.size() != 0) begin
          next_beat = beat_queue.pop_front();
          cur_beat <= next_beat;
          req_type <= next_beat.kind;
          sample   <= next_beat.sample;
          mask_bit <= next_beat.mask;
          in_valid <= 1'b1;
          if (tx_busy && !quiet_tail && $urandom_range(0, 7) == 0)
            tx_gap = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_mode_left == 0) begin
        rx_mode_left = $urandom_range(100, 400);
        rx_busy      = ($urandom_range(0, 2) != 0);
      end else begin
        rx_mode_left--;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        rx_hold   = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (rx_busy && !quiet_tail && $urandom_range(0, 11) == 0) begin
        rx_hold = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    pixel_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", out_value, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_value !== want.value)
          report_mismatch("out_value", out_value, want.value);
        if (kept_original !== want.kept)
          report_mismatch("kept_original", kept_original, want.kept);
        if (last_pixel !== want.last)
          report_mismatch("last_pixel", last_pixel, want.last);
        results_checked++;
        if (want.last) frames_closed++;
      end
    end
  end

  function automatic mfnm_pkg::value_t pick_sample(input int style);
    if (style == 1) begin
      case ($urandom_range(0, 4))
        0:       return mfnm_pkg::value_t'(-32768);
        1:       return mfnm_pkg::value_t'(32767);
        2:       return mfnm_pkg::value_t'(-1);
        3:       return '0;
        default: return mfnm_pkg::value_t'(1);
      endcase
    end
    return mfnm_pkg::value_t'($urandom);
  endfunction

  task automatic queue_pixel(input mfnm_pkg::value_t v, input logic m);
    beat_t b;
    b.kind   = mfnm_pkg::REQ_PIXEL;
    b.sample = v;
    b.mask   = m;
    beat_queue.push_back(b);
  endtask

  task automatic queue_drain();
    beat_t b;
    b.kind   = mfnm_pkg::REQ_DRAIN;
    b.sample = mfnm_pkg::value_t'($urandom);
    b.mask   = 1'($urandom_range(0, 1));
    beat_queue.push_back(b);
  endtask

  task automatic wait_idle();
    while (beat_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_side(input logic [mfnm_pkg::CFG_W-1:0] raw);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we      <= 1'b1;
    matrix_size <= raw;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (raw < mfnm_pkg::MIN_SIZE) side = mfnm_pkg::MIN_SIZE;
    else if (raw > mfnm_pkg::MAX_DIM) side = mfnm_pkg::MAX_DIM;
    else side = 32'(raw);
    fed_count = 0;
    row_pos   = 0;
    col_pos   = 0;
    settings_written++;
    @(negedge clk_i);
  endtask

  // one frame at the current size; a cut >= 0 stops it after that many pixels
  task automatic run_frame(input int cut);
    int               n;
    int               style;
    mfnm_pkg::value_t flat;
    n     = side;
    style = $urandom_range(0, 5);
    flat  = $urandom_range(0, 1) ? mfnm_pkg::value_t'(32767) :
                                   mfnm_pkg::value_t'(-32768);
    for (int i = 0; i < n * n; i++) begin
      if (i == cut) return;
      if ($urandom_range(0, 29) == 0) queue_drain();
      if (style == 5) queue_pixel(flat, $urandom_range(0, 9) == 0);
      else queue_pixel(pick_sample(int'(style == 4)), $urandom_range(0, 3) == 0);
      frame_beats++;
    end
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 4) == 0) queue_pixel(pick_sample(0), 1'($urandom_range(0, 1)));
      else queue_drain();
      frame_beats++;
    end
  endtask

  initial begin : stimulus
    logic [mfnm_pkg::CFG_W-1:0] raw;
    int stop_at;
    int nframes;
    for (int i = 0; i < PIX_DEPTH; i++) pix_line[i] = '0;
    for (int i = 0; i < MASK_DEPTH; i++) mask_line[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset size, receiver held off so the input backs up
    for (int i = 0; i < 2 * mfnm_pkg::RESET_SIZE + 9; i++)
      queue_pixel(pick_sample(0), $urandom_range(0, 3) == 0);
    hold_request = 1'b1;

    // clamp up from zero; negative extreme stencil, early drains, pixel in flush
    set_side('0);
    queue_drain();
    queue_pixel(mfnm_pkg::value_t'(32767), 1'b0);
    queue_pixel(mfnm_pkg::value_t'(-32768), 1'b0);
    queue_pixel(mfnm_pkg::value_t'(5), 1'b1);
    queue_pixel(mfnm_pkg::value_t'(-32768), 1'b0);
    queue_drain();
    queue_pixel(mfnm_pkg::value_t'(-1), 1'b0);
    queue_pixel(mfnm_pkg::value_t'(-32768), 1'b0);
    queue_pixel(mfnm_pkg::value_t'(0), 1'b1);
    queue_pixel(mfnm_pkg::value_t'(-32768), 1'b0);
    queue_pixel(mfnm_pkg::value_t'(-32768), 1'b1);
    queue_drain();
    queue_pixel(mfnm_pkg::value_t'(1234), 1'b1);
    queue_drain();
    // positive extreme stencil, masked border pixels
    queue_pixel(mfnm_pkg::value_t'(-32768), 1'b1);
    queue_pixel(mfnm_pkg::value_t'(32767), 1'b0);
    queue_pixel(mfnm_pkg::value_t'(-1), 1'b1);
    queue_pixel(mfnm_pkg::value_t'(32767), 1'b0);
    queue_pixel(mfnm_pkg::value_t'(-32768), 1'b0);
    queue_pixel(mfnm_pkg::value_t'(32767), 1'b1);
    queue_pixel(mfnm_pkg::value_t'(1), 1'b0);
    queue_pixel(mfnm_pkg::value_t'(32767), 1'b0);
    queue_pixel(mfnm_pkg::value_t'(0), 1'b1);
    queue_drain();
    queue_drain();
    queue_drain();

    // largest size, then clamp down from all ones; a few rows each
    set_side(9'd256);
    for (int i = 0; i < 2 * mfnm_pkg::MAX_DIM + 12; i++)
      queue_pixel(pick_sample($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    set_side(SIZE_ALL_ONES);
    for (int i = 0; i < mfnm_pkg::MAX_DIM + 8; i++)
      queue_pixel(pick_sample($urandom_range(0, 1)), $urandom_range(0, 3) == 0);

    stop_at = frame_beats + RANDOM_BEATS;
    while (frame_beats < stop_at) begin
      case ($urandom_range(0, 9))
        0:       raw = mfnm_pkg::CFG_W'($urandom_range(0, 2));
        1, 2:    raw = mfnm_pkg::CFG_W'($urandom_range(9, 12));
        default: raw = mfnm_pkg::CFG_W'($urandom_range(3, 8));
      endcase
      set_side(raw);
      if (frame_beats > stop_at - RANDOM_BEATS / 5) quiet_tail = 1'b1;
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++)
        run_frame((f == nframes - 1 && $urandom_range(0, 4) == 0) ?
                  $urandom_range(0, side * side - 1) : -1);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("%0d beats taken over %0d size settings, %0d results checked",
             beats_taken, settings_written, results_checked);
    $display("%0d frames closed, sizes from 3 to 256 with clamping and cut frames",
             frames_closed);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
